// ----- src/trpp_pkg.sv -----
// Shared types, constants and tree helpers for the region tree page prefetcher.
package trpp_pkg;

    localparam int PAGE_W      = 19;
    localparam int NODE_W      = 6;
    localparam int LEAF_W      = 5;
    localparam int NODES       = 63;
    localparam int LEAVES      = 32;
    localparam int FIRST_LEAF  = 31;
    localparam int LEVELS      = 6;
    localparam int LEVEL_W     = 3;
    localparam int REGION_LSB  = 9;
    localparam int GROUP_LSB   = 4;
    localparam int REGION_W    = PAGE_W - REGION_LSB;
    localparam int TOP_LEVEL   = 5;
    localparam int REGION_BITS = 10;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_LEVEL,
        ST_EMIT,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic                fill;
        logic [NODES-1:0]    word;
        logic [LEAVES-1:0]   new_leaves;
    } t_level_res;

    // Mark every node of the subtree rooted at node (the node included).
    function automatic logic [NODES-1:0] subtree_mask(input logic [NODE_W-1:0] node);
        logic [NODES-1:0] mask;
        logic [NODE_W:0]  mp;
        logic [NODE_W:0]  np;
        mask = '0;
        np   = {1'b0, node} + 7'd1;
        for (int m = 0; m < NODES; m++) begin
            mp = 7'(m + 1);
            for (int j = 0; j < LEVELS; j++) begin
                if ((mp >> j) == np) begin
                    mask[m] = 1'b1;
                end
            end
        end
        return mask;
    endfunction

endpackage

// ----- src/tree_region_page_prefetcher_unit.sv -----
// Top level of the region tree page prefetcher: sequencer around the tree memory.
// Sequence: after the transfer on start the unit reads the tree word, checks the leaf,
// runs five ancestor checks, then strobes the groups one per cycle, o_last on the final one,
// and writes the word back; busy stays high throughout. A fault on a marked leaf ends
// after the check with no groups emitted.
// Reset: a clearing pass writes zero to all 2^REGION_BITS tree words, busy stays high.
// The receiver cannot stall: each result is present for exactly one cycle.
module tree_region_page_prefetcher_unit #(
    parameter int REGION_BITS = trpp_pkg::REGION_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [trpp_pkg::PAGE_W-1:0] i_fault_page,
    output logic                        o_valid,
    output logic [trpp_pkg::PAGE_W-1:0] o_group_page,
    output logic                        o_last
);

    localparam int NODES  = trpp_pkg::NODES;
    localparam int LEAVES = trpp_pkg::LEAVES;
    localparam int LEVELS = trpp_pkg::LEVELS;

    trpp_pkg::t_state r_state, n_state;

    logic [trpp_pkg::PAGE_W-1:0]  r_page, n_page;
    logic [NODES-1:0]             r_word, n_word;
    logic [LEAVES-1:0]            r_pend [0:LEVELS-1];
    logic [LEAVES-1:0]            n_pend [0:LEVELS-1];
    logic [trpp_pkg::LEVEL_W-1:0] r_level, n_level;
    logic [REGION_BITS-1:0]       r_clr_addr, n_clr_addr;

    logic [REGION_BITS-1:0]       slot;
    logic [trpp_pkg::LEAF_W-1:0]  leaf;
    logic [NODES-1:0]             rd_word;
    logic                         leaf_marked;
    trpp_pkg::t_level_res         lvl;

    logic [trpp_pkg::LEVEL_W-1:0] sel_level;
    logic [trpp_pkg::LEAF_W-1:0]  sel_leaf;
    logic [LEAVES-1:0]            sel_mask;
    logic [LEAVES-1:0]            pend_all;
    logic                         emit_last;

    logic                         ram_we;
    logic [REGION_BITS-1:0]       ram_waddr;
    logic [NODES-1:0]             ram_wdata;
    logic                         ram_re;

    // Region number picks the tree word; low bits only when the store is smaller.
    assign slot = REGION_BITS'(r_page[trpp_pkg::PAGE_W-1:trpp_pkg::REGION_LSB]);
    assign leaf = r_page[trpp_pkg::REGION_LSB-1:trpp_pkg::GROUP_LSB];
    assign leaf_marked = rd_word[trpp_pkg::FIRST_LEAF + int'(leaf)];

    trpp_ram #(
        .WIDTH      (NODES),
        .DEPTH_LOG2 (REGION_BITS)
    ) u_tree_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (slot),
        .o_rdata (rd_word)
    );

    trpp_level u_level (
        .i_word  (r_word),
        .i_leaf  (leaf),
        .i_level (r_level),
        .o_res   (lvl)
    );

    // Pick the next group: earliest fill level first, then leftmost leaf.
    always_comb begin
        sel_level = trpp_pkg::LEVEL_W'(0);
        sel_leaf  = '0;
        pend_all  = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            pend_all = pend_all | r_pend[l];
            if (r_pend[l] != '0) begin
                sel_level = trpp_pkg::LEVEL_W'(l);
            end
        end
        sel_mask = r_pend[sel_level];
        for (int b = LEAVES - 1; b >= 0; b--) begin
            if (sel_mask[b]) begin
                sel_leaf = trpp_pkg::LEAF_W'(b);
            end
        end
        // last when one pending group remains
        emit_last = ((pend_all & (pend_all - 32'd1)) == '0);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            trpp_pkg::ST_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = trpp_pkg::ST_IDLE;
                end
            end
            trpp_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = trpp_pkg::ST_READ;
                end
            end
            trpp_pkg::ST_READ: begin
                n_state = trpp_pkg::ST_CHECK;
            end
            trpp_pkg::ST_CHECK: begin
                // drop a fault on a leaf that is already marked
                n_state = leaf_marked ? trpp_pkg::ST_IDLE : trpp_pkg::ST_LEVEL;
            end
            trpp_pkg::ST_LEVEL: begin
                if (r_level == trpp_pkg::LEVEL_W'(trpp_pkg::TOP_LEVEL)) begin
                    n_state = trpp_pkg::ST_EMIT;
                end
            end
            trpp_pkg::ST_EMIT: begin
                if (emit_last) begin
                    n_state = trpp_pkg::ST_WRITE;
                end
            end
            trpp_pkg::ST_WRITE: begin
                n_state = trpp_pkg::ST_IDLE;
            end
            default: begin
                n_state = trpp_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_page     = r_page;
        n_word     = r_word;
        n_level    = r_level;
        n_clr_addr = r_clr_addr;
        for (int l = 0; l < LEVELS; l++) begin
            n_pend[l] = r_pend[l];
        end
        case (r_state)
            trpp_pkg::ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
            end
            trpp_pkg::ST_IDLE: begin
                n_page = i_fault_page;
            end
            trpp_pkg::ST_CHECK: begin
                // mark the faulting leaf and queue its group first
                n_word = rd_word;
                n_word[trpp_pkg::FIRST_LEAF + int'(leaf)] = 1'b1;
                for (int l = 0; l < LEVELS; l++) begin
                    n_pend[l] = '0;
                end
                n_pend[0] = 32'd1 << leaf;
                n_level   = trpp_pkg::LEVEL_W'(1);
            end
            trpp_pkg::ST_LEVEL: begin
                // fill the ancestor's subtree and queue the leaves it newly marks
                if (lvl.fill) begin
                    n_word           = lvl.word;
                    n_pend[r_level]  = lvl.new_leaves;
                end
                n_level = r_level + 1'b1;
            end
            trpp_pkg::ST_EMIT: begin
                n_pend[sel_level][sel_leaf] = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Outputs and memory controls.
    always_comb begin
        busy         = (r_state != trpp_pkg::ST_IDLE);
        o_valid      = (r_state == trpp_pkg::ST_EMIT);
        o_last       = emit_last;
        o_group_page = {r_page[trpp_pkg::PAGE_W-1:trpp_pkg::REGION_LSB], sel_leaf,
                        trpp_pkg::GROUP_LSB'(0)};
        ram_re       = (r_state == trpp_pkg::ST_READ);
        ram_we       = 1'b0;
        ram_waddr    = slot;
        ram_wdata    = r_word;
        case (r_state)
            trpp_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            trpp_pkg::ST_WRITE: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= trpp_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_level    <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_level    <= n_level;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_page <= n_page;
        r_word <= n_word;
        for (int l = 0; l < LEVELS; l++) begin
            r_pend[l] <= n_pend[l];
        end
    end

endmodule

// ----- src/trpp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module trpp_ram #(
    parameter int WIDTH      = 63,
    parameter int DEPTH_LOG2 = 10
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [DEPTH_LOG2-1:0] i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic                  i_re,
    input  logic [DEPTH_LOG2-1:0] i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [0:(2**DEPTH_LOG2)-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/trpp_level.sv -----
// One ancestor check: count marks in the subtree and fill it past the half mark.
module trpp_level (
    input  logic [trpp_pkg::NODES-1:0]   i_word,
    input  logic [trpp_pkg::LEAF_W-1:0]  i_leaf,
    input  logic [trpp_pkg::LEVEL_W-1:0] i_level,
    output trpp_pkg::t_level_res         o_res
);

    logic [trpp_pkg::NODE_W-1:0] leaf_pos;
    logic [trpp_pkg::NODE_W-1:0] anc;
    logic [trpp_pkg::NODES-1:0]  mask;
    logic [trpp_pkg::NODE_W-1:0] cnt;
    logic [trpp_pkg::NODE_W:0]   thresh;

    always_comb begin
        // leaf node plus one, shifted up by the level, gives ancestor plus one
        leaf_pos = {1'b0, i_leaf} + 6'd32;
        anc      = (leaf_pos >> i_level) - 6'd1;
        mask     = trpp_pkg::subtree_mask(anc);
        cnt      = 6'($countones(i_word & mask));
        // more than half of 2^(level+1)-1 nodes means at least 2^level
        thresh   = 7'd1 << i_level;
        o_res.fill       = ({1'b0, cnt} >= thresh);
        o_res.word       = i_word | mask;
        o_res.new_leaves = mask[trpp_pkg::NODES-1:trpp_pkg::FIRST_LEAF]
                         & ~i_word[trpp_pkg::NODES-1:trpp_pkg::FIRST_LEAF];
    end

endmodule
